// ----- sv/step_response_metrics_assert.svh -----
// Assertion macros shared by the step response metrics RTL
`ifndef STEP_RESPONSE_METRICS_ASSERT_SVH
`define STEP_RESPONSE_METRICS_ASSERT_SVH

// Implication checked every clock, masked during reset
`define SRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define SRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/srm_pkg.sv -----
package srm_pkg;

  localparam int unsigned SpW   = 31;
  localparam int unsigned CntW  = 16;
  localparam int unsigned DW    = 32;
  localparam int unsigned SumW  = 50;
  localparam int unsigned DivW  = 64;

  localparam logic [SpW-1:0]  SpReset  = 31'd13107200;
  localparam logic [CntW-1:0] CntReset = 16'd500;

  localparam logic [0:0] RegSetpoint = 1'b0;
  localparam logic [0:0] RegCount    = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StDivOv,
    StDivSe,
    StDivJt,
    StOut
  } srm_state_e;

  // controller to datapath
  typedef struct packed {
    logic       sample;    // absorb one input beat
    logic       div_start; // launch divider
    logic [1:0] div_sel;   // 0 overshoot, 1 steady error, 2 jitter
    logic       div_done_capture;
    logic       finish;    // load output register, clear run
    logic       out_pop;   // output beat taken
  } srm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;     // sample being absorbed ends the run
    logic div_busy;
    logic out_full;
  } srm_sts_t;

  localparam logic [1:0] DivOv = 2'd0;
  localparam logic [1:0] DivSe = 2'd1;
  localparam logic [1:0] DivJt = 2'd2;

endpackage

// ----- sv/step_response_metrics.sv -----
// Step response metrics.
// Input channel s_axis: one beat per sample (time, speed, drive). After
// sample_count beats the run ends and one result beat is produced on
// m_axis carrying rise time, overshoot, steady error, settle time, peak
// drive, ripple and jitter; run state then clears, registers persist.
// Flow: ordinary samples are taken back to back. The last sample of a run
// starts three divisions (overshoot, steady error, jitter) in turn on one
// shared restoring divider; each runs as launch, 64 quotient bits and
// capture, and m_axis_tvalid rises after the third capture.
// s_axis_tready is low during the divisions and while a previous result still
// waits in the output register when the next one is ready.
// Reset (rst_ni low, async) restores setpoint 200.0 and sample_count 500
// and clears all run state; no clearing pass is needed.
// A stalled receiver holds the result in the output register; new samples
// are still taken until the following run end.
// APB: register 0 setpoint at 0x0, register 1 sample_count at 0x4.
module step_response_metrics #(
  parameter int unsigned MaxSamples = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] sample_time, [63:32] speed, [95:64] drive
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] rise_ticks, [32] rise_valid, [64:33] overshoot,
  // [96:65] steady_error, [128:97] settle_stamp, [129] settle_valid,
  // [161:130] peak_drive, [193:162] ripple, [225:194] jitter, rest zero
  output logic [231:0] m_axis_tdata
);
  logic [srm_pkg::SpW-1:0]  sp_q;
  logic [srm_pkg::CntW-1:0] cnt_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= srm_pkg::SpReset;
      cnt_q <= srm_pkg::CntReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == srm_pkg::RegSetpoint) sp_q <= pwdata[30:0];
      else cnt_q <= pwdata[15:0];
    end
  end
  always_comb begin
    case (paddr[2])
      srm_pkg::RegSetpoint: prdata = {1'b0, sp_q};
      default:              prdata = {16'd0, cnt_q};
    endcase
  end

  srm_pkg::srm_cmd_t cmd;
  srm_pkg::srm_sts_t sts;

  srm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logic [31:0] rt, ov, st, pd, rp, jt;
  logic signed [31:0] se;
  logic rv, sv;

  srm_dp #(.MaxSamples(MaxSamples)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .setpoint_i      (sp_q),
    .count_i         (cnt_q),
    .sample_time_i   (s_axis_tdata[31:0]),
    .speed_i         ($signed(s_axis_tdata[63:32])),
    .drive_i         ($signed(s_axis_tdata[95:64])),
    .rise_ticks_o    (rt),
    .rise_valid_o    (rv),
    .overshoot_o     (ov),
    .steady_error_o  (se),
    .settle_stamp_o  (st),
    .settle_valid_o  (sv),
    .peak_drive_o    (pd),
    .ripple_o        (rp),
    .jitter_o        (jt),
    .out_valid_o     (m_axis_tvalid)
  );

  assign m_axis_tdata = {6'd0, jt, rp, pd, sv, st, se, ov, rv, rt};
endmodule

// ----- sv/srm_div.sv -----
// Unsigned restoring divider, one quotient bit per clock.
module srm_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [srm_pkg::DivW-1:0] num_i,
  input  logic [srm_pkg::DivW-1:0] den_i,
  output logic                    busy_o,
  output logic [srm_pkg::DivW-1:0] quo_o
);
  localparam int unsigned W = srm_pkg::DivW;

  logic [W-1:0]   quo_q, quo_d, den_q, den_d;
  logic [W:0]     rem_q, rem_d;
  logic [6:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [W:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 7'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-1:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

// ----- sv/srm_ctrl.sv -----
// Sequencer: absorb samples, run three divisions after the last, emit.
module srm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  srm_pkg::srm_sts_t sts_i,
  output srm_pkg::srm_cmd_t cmd_o
);
  `include "step_response_metrics_assert.svh"

  srm_pkg::srm_state_e state_q, state_d;
  logic started_q, started_d;

  always_comb begin
    state_d   = state_q;
    started_d = 1'b0;
    case (state_q)
      srm_pkg::StIdle: begin
        if (in_valid_i && in_ready_o && sts_i.last) begin
          state_d   = srm_pkg::StDivOv;
          started_d = 1'b0;
        end
      end
      srm_pkg::StDivOv, srm_pkg::StDivSe, srm_pkg::StDivJt: begin
        started_d = 1'b1;
        if (started_q && !sts_i.div_busy) begin
          started_d = 1'b0;
          case (state_q)
            srm_pkg::StDivOv: state_d = srm_pkg::StDivSe;
            srm_pkg::StDivSe: state_d = srm_pkg::StDivJt;
            default:          state_d = srm_pkg::StOut;
          endcase
        end
      end
      srm_pkg::StOut: begin
        if (!sts_i.out_full || out_ready_i) begin
          state_d = srm_pkg::StIdle;
        end
      end
      default: state_d = srm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = (state_q == srm_pkg::StIdle);
    cmd_o.sample     = in_valid_i && in_ready_o;
    cmd_o.out_pop    = out_ready_i && sts_i.out_full;
    case (state_q)
      srm_pkg::StDivOv: cmd_o.div_sel = srm_pkg::DivOv;
      srm_pkg::StDivSe: cmd_o.div_sel = srm_pkg::DivSe;
      srm_pkg::StDivJt: cmd_o.div_sel = srm_pkg::DivJt;
      default:          cmd_o.div_sel = srm_pkg::DivOv;
    endcase
    if (state_q == srm_pkg::StDivOv || state_q == srm_pkg::StDivSe ||
        state_q == srm_pkg::StDivJt) begin
      cmd_o.div_start        = !started_q;
      cmd_o.div_done_capture = started_q && !sts_i.div_busy;
    end
    if (state_q == srm_pkg::StOut) begin
      cmd_o.finish = !sts_i.out_full || out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srm_pkg::StIdle;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end

  `SRM_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni,
                  state_q != srm_pkg::StIdle, !in_ready_o, "input accepted while busy")
  `SRM_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, cmd_o.div_start, sts_i.div_busy,
                   "divider did not start")
  `SRM_ASSERT_NEXT(a_last_to_div, clk_i, rst_ni, cmd_o.sample && sts_i.last,
                   state_q == srm_pkg::StDivOv, "run end not followed by division")
endmodule

// ----- sv/srm_dp.sv -----
// Per-sample trackers, final metric assembly and output register.
module srm_dp #(
  parameter int unsigned MaxSamples = 65535
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  srm_pkg::srm_cmd_t        cmd_i,
  output srm_pkg::srm_sts_t        sts_o,
  input  logic [srm_pkg::SpW-1:0]  setpoint_i,
  input  logic [srm_pkg::CntW-1:0] count_i,
  input  logic [31:0]              sample_time_i,
  input  logic signed [31:0]       speed_i,
  input  logic signed [31:0]       drive_i,
  output logic [31:0]              rise_ticks_o,
  output logic                     rise_valid_o,
  output logic [31:0]              overshoot_o,
  output logic signed [31:0]       steady_error_o,
  output logic [31:0]              settle_stamp_o,
  output logic                     settle_valid_o,
  output logic [31:0]              peak_drive_o,
  output logic [31:0]              ripple_o,
  output logic [31:0]              jitter_o,
  output logic                     out_valid_o
);
  `include "step_response_metrics_assert.svh"

  localparam int unsigned IW = (MaxSamples > 65535) ? 24 : 16;
  localparam int unsigned W  = srm_pkg::DivW;
  localparam int unsigned SW = srm_pkg::SumW;

  // effective run length and window geometry
  logic [IW-1:0] n_eff, cnt10, ws;
  logic [30:0]   sp;
  always_comb begin
    n_eff = (count_i == '0) ? IW'(1) : IW'(count_i);
    if (32'(n_eff) > 32'(MaxSamples)) n_eff = IW'(MaxSamples);
    // n/10 by reciprocal: floor(n*52429/2^19) exact for n < 2^18
    cnt10 = IW'((40'(n_eff) * 40'd52429) >> 19);
    ws    = n_eff - cnt10;
    sp    = (setpoint_i == '0) ? 31'd1 : setpoint_i;
  end

  logic [IW-1:0]      idx_q;
  logic signed [31:0] peak_q, wmin_q, wmax_q, prev_u_q;
  logic [31:0]        low_t_q, high_t_q, settle_q;
  logic               low_s_q, high_s_q, ever_q, prev_ob_q;
  logic signed [SW-1:0] err_q;
  logic [SW-1:0]      chg_q;
  logic [32:0]        pabs_q;

  // per-sample arithmetic
  logic signed [36:0] y10, sp1, sp9;
  logic signed [33:0] dev, adev;
  logic signed [39:0] dev50;
  logic               outb, in_win, win_next, last;
  logic signed [33:0] du, adu;
  logic signed [32:0] au;
  always_comb begin
    y10   = 37'(speed_i) * 37'sd10;
    sp1   = 37'($signed({1'b0, sp}));
    sp9   = sp1 * 37'sd9;
    dev   = 34'(speed_i) - 34'($signed({1'b0, sp}));
    adev  = dev[33] ? -dev : dev;
    dev50 = 40'(adev) * 40'sd50;
    outb  = dev50 > 40'($signed({1'b0, sp}));
    in_win   = idx_q >= ws;
    win_next = idx_q > ws;
    // full-scale drive swing needs 33 bits
    du    = 34'(drive_i) - 34'(prev_u_q);
    adu   = du[33] ? -du : du;
    au    = drive_i[31] ? -33'(drive_i) : 33'(drive_i);
    last  = !((IW+1)'(idx_q) + (IW+1)'(1) < (IW+1)'(n_eff));
  end
  assign sts_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; peak_q <= 32'sh8000_0000; low_t_q <= '0; low_s_q <= 1'b0;
      high_t_q <= '0; high_s_q <= 1'b0; ever_q <= 1'b0; prev_ob_q <= 1'b0;
      settle_q <= '0; err_q <= '0; wmin_q <= 32'sh7fff_ffff;
      wmax_q <= 32'sh8000_0000; prev_u_q <= '0; chg_q <= '0; pabs_q <= '0;
    end else if (cmd_i.finish) begin
      idx_q <= '0; peak_q <= 32'sh8000_0000; low_t_q <= '0; low_s_q <= 1'b0;
      high_t_q <= '0; high_s_q <= 1'b0; ever_q <= 1'b0; prev_ob_q <= 1'b0;
      settle_q <= '0; err_q <= '0; wmin_q <= 32'sh7fff_ffff;
      wmax_q <= 32'sh8000_0000; prev_u_q <= '0; chg_q <= '0; pabs_q <= '0;
    end else if (cmd_i.sample) begin
      if (speed_i > peak_q) peak_q <= speed_i;
      if (!low_s_q && y10 >= sp1) begin
        low_s_q <= 1'b1; low_t_q <= sample_time_i;
      end
      if (!high_s_q && y10 >= sp9) begin
        high_s_q <= 1'b1; high_t_q <= sample_time_i;
      end
      if (prev_ob_q) settle_q <= sample_time_i;
      if (outb) ever_q <= 1'b1;
      prev_ob_q <= outb;
      if (in_win) begin
        err_q <= err_q + SW'($signed({1'b0, sp})) - SW'(speed_i);
        if (drive_i < wmin_q) wmin_q <= drive_i;
        if (drive_i > wmax_q) wmax_q <= drive_i;
        if (win_next) chg_q <= chg_q + SW'(adu);
      end
      prev_u_q <= drive_i;
      if (au > $signed(pabs_q)) pabs_q <= au;
      if (!last) idx_q <= idx_q + IW'(1);
    end
  end

  // divider operands
  logic [W-1:0] num, den, quo;
  logic         div_busy;
  logic [31:0]  ov_excess;
  logic         err_neg;
  logic [SW-1:0] err_mag;
  always_comb begin
    ov_excess = 32'(peak_q) - 32'({1'b0, sp});
    err_neg   = err_q[SW-1];
    err_mag   = err_neg ? SW'(-err_q) : SW'(err_q);
    case (cmd_i.div_sel)
      srm_pkg::DivOv: begin
        // excess * 100 * 65536 = excess * (2^22 + 2^21 + 2^18)
        num = (W'(ov_excess) << 22) + (W'(ov_excess) << 21) + (W'(ov_excess) << 18);
        den = W'(sp);
      end
      srm_pkg::DivSe: begin
        num = W'(err_mag);
        den = (cnt10 == '0) ? W'(1) : W'(cnt10);
      end
      default: begin
        num = W'(chg_q);
        den = (cnt10 < IW'(2)) ? W'(1) : W'(cnt10 - IW'(1));
      end
    endcase
  end

  srm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );
  assign sts_o.div_busy = div_busy;

  logic [31:0] ov_q, se_q, jt_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_done_capture) begin
      case (cmd_i.div_sel)
        srm_pkg::DivOv: begin
          if (peak_q <= $signed({1'b0, sp})) ov_q <= '0;
          else ov_q <= (quo[W-1:32] != '0) ? 32'hffff_ffff : quo[31:0];
        end
        srm_pkg::DivSe: begin
          if (cnt10 == '0) se_q <= '0;
          else if (!err_neg)
            se_q <= (quo > W'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo[31:0];
          else
            se_q <= (quo > W'(33'h8000_0000)) ? 32'h8000_0000 : 32'(-quo[31:0]);
        end
        default: begin
          if (cnt10 < IW'(2)) jt_q <= '0;
          else jt_q <= (quo[W-1:32] != '0) ? 32'hffff_ffff : quo[31:0];
        end
      endcase
    end
  end

  // output register
  logic full_q;
  logic rv, sv;
  assign rv = low_s_q && high_s_q;
  assign sv = ever_q && !prev_ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (cmd_i.finish) full_q <= 1'b1;
    else if (cmd_i.out_pop) full_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rise_ticks_o    <= rv ? high_t_q - low_t_q : '0;
      rise_valid_o    <= rv;
      overshoot_o     <= ov_q;
      steady_error_o  <= $signed(se_q);
      settle_stamp_o  <= sv ? settle_q : '0;
      settle_valid_o  <= sv;
      peak_drive_o    <= pabs_q[31:0];
      ripple_o        <= (wmax_q >= wmin_q) ? 32'(wmax_q - wmin_q) : '0;
      jitter_o        <= jt_q;
    end
  end
  assign out_valid_o    = full_q;
  assign sts_o.out_full = full_q;

  `SRM_ASSERT_NEXT(a_finish_full, clk_i, rst_ni, cmd_i.finish, full_q,
                   "result not registered")
  `SRM_ASSERT_NEXT(a_finish_clear, clk_i, rst_ni, cmd_i.finish, idx_q == '0,
                   "run state not cleared")
  `SRM_ASSERT_NEXT(a_pop_empty, clk_i, rst_ni, cmd_i.out_pop && !cmd_i.finish, !full_q,
                   "output register not emptied")
endmodule
